### rtl/core/rgb_point_operation_pipeline_assert.svh
// assertion macros for the rgb point operation pipeline
// clocked on aclk, disabled while aresetn is low; no other dependencies
`ifndef RGB_POINT_OPERATION_PIPELINE_ASSERT_SVH
`define RGB_POINT_OPERATION_PIPELINE_ASSERT_SVH

// same-cycle implication
`define RPOP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RPOP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/rpop_pkg.sv
// shared types and constants for the rgb point operation pipeline
// no dependencies
package rpop_pkg;

    localparam int CHANNEL_BITS   = 8;
    localparam int GAIN_FRAC_BITS = 8;
    localparam int GAIN_BITS      = 16;
    localparam int OFFSET_BITS    = CHANNEL_BITS + 1;
    localparam int NUM_CH         = 3;
    localparam int LUT_DEPTH      = 1 << CHANNEL_BITS;
    localparam int PROD_BITS      = CHANNEL_BITS + GAIN_BITS;
    localparam int SHIFT_BITS     = PROD_BITS + 1 - GAIN_FRAC_BITS;
    localparam int SUM_BITS       = CHANNEL_BITS + 2;
    localparam int OPS_BITS       = 4;
    localparam int KEEP_BITS      = 3;
    localparam int CFG_IDX_BITS   = 2;
    localparam int CFG_DATA_BITS  = 16;

    typedef logic [CHANNEL_BITS-1:0] chan_t;

    localparam chan_t CH_MAX = '1;

    // gain of one and rounding half, both in the gain's fixed-point format
    localparam logic [GAIN_BITS-1:0] UNITY_GAIN = GAIN_BITS'(1 << GAIN_FRAC_BITS);
    localparam logic [PROD_BITS:0]   RND_HALF   = (PROD_BITS+1)'(1 << (GAIN_FRAC_BITS - 1));

    // most negative raw offset, clamped to one above it when written
    localparam logic [OFFSET_BITS-1:0] OFFSET_RAW_MIN = {1'b1, {(OFFSET_BITS-1){1'b0}}};
    localparam logic [OFFSET_BITS-1:0] OFFSET_MIN     = OFFSET_RAW_MIN + OFFSET_BITS'(1);

    // op enable bit positions
    localparam int EN_INVERT   = 0;
    localparam int EN_CONTRAST = 1;
    localparam int EN_BRIGHT   = 2;
    localparam int EN_GAMMA    = 3;

    // request functions
    localparam logic FUNC_PIXEL     = 1'b0;
    localparam logic FUNC_LUT_WRITE = 1'b1;

    // channel order in per-channel arrays
    localparam int CH_BLUE  = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_RED   = 2;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_OP_ENABLES        = 2'd0,
        REG_CONTRAST_GAIN     = 2'd1,
        REG_BRIGHTNESS_OFFSET = 2'd2,
        REG_CHANNEL_KEEP      = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic  func;
        chan_t in_blue;
        chan_t in_green;
        chan_t in_red;
        chan_t lut_index;
        chan_t lut_value;
    } pix_in_t;

    typedef struct packed {
        chan_t out_blue;
        chan_t out_green;
        chan_t out_red;
    } pix_out_t;

endpackage

### rtl/core/rpop_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module rpop_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/rgb_point_operation_pipeline.sv
// throughput: one request per cycle; each stage moves on as soon as the one after has room
// stages: input register, invert and gain multiply, round/brightness and gamma ram read, output
// gamma table: three ram copies so all channels look up in the same cycle; undefined until written
// reset (aresetn low, synchronous): pipeline emptied, configuration registers to their defaults
// uses rpop_pkg, rpop_ram and rgb_point_operation_pipeline_assert.svh
module rgb_point_operation_pipeline (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic [rpop_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [rpop_pkg::CFG_DATA_BITS-1:0]     cfg_wdata,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  rpop_pkg::pix_in_t                      s_data,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output rpop_pkg::pix_out_t                     m_data
);

    `include "rgb_point_operation_pipeline_assert.svh"

    // configuration
    logic [rpop_pkg::OPS_BITS-1:0]    op_enables_reg;
    logic [rpop_pkg::GAIN_BITS-1:0]   contrast_gain_reg;
    logic [rpop_pkg::OFFSET_BITS-1:0] brightness_offset_reg;
    logic [rpop_pkg::KEEP_BITS-1:0]   channel_keep_reg;
    logic [rpop_pkg::OFFSET_BITS-1:0] offset_wr;

    // pipeline
    logic                          v0_reg, v0_next;
    rpop_pkg::pix_in_t             in0_reg, in0_next;
    logic                          v1_reg, v1_next;
    logic                          func1_reg;
    rpop_pkg::chan_t               lidx1_reg, lval1_reg;
    logic [rpop_pkg::PROD_BITS-1:0] prod1_reg [rpop_pkg::NUM_CH];
    logic [rpop_pkg::PROD_BITS-1:0] prod1_next [rpop_pkg::NUM_CH];
    logic                          v2_reg, v2_next;
    rpop_pkg::chan_t               val2_reg [rpop_pkg::NUM_CH];
    rpop_pkg::chan_t               val2_next [rpop_pkg::NUM_CH];
    logic                          m_valid_reg, m_valid_next;
    rpop_pkg::pix_out_t            m_data_reg, m_data_next;

    logic rdy_out, rdy2, rdy1, rdy0, s_fire, adv1, adv2;
    logic ram_we, ram_re;

    rpop_pkg::chan_t                 chan_in [rpop_pkg::NUM_CH];
    rpop_pkg::chan_t                 inv_val [rpop_pkg::NUM_CH];
    logic [rpop_pkg::GAIN_BITS-1:0]  gain_sel;
    logic [rpop_pkg::PROD_BITS:0]    rnd_val [rpop_pkg::NUM_CH];
    logic [rpop_pkg::SHIFT_BITS-1:0] shf_val [rpop_pkg::NUM_CH];
    rpop_pkg::chan_t                 con_val [rpop_pkg::NUM_CH];
    logic [rpop_pkg::SUM_BITS-1:0]   sum_val [rpop_pkg::NUM_CH];
    rpop_pkg::chan_t                 brt_val [rpop_pkg::NUM_CH];
    rpop_pkg::chan_t                 gam_val [rpop_pkg::NUM_CH];
    rpop_pkg::chan_t                 fin_val [rpop_pkg::NUM_CH];
    rpop_pkg::chan_t                 ram_rd  [rpop_pkg::NUM_CH];
    logic [rpop_pkg::KEEP_BITS-1:0]  keep;

    // ---------------- configuration registers ----------------

    // offset saturated to -255 when the raw code is -256
    assign offset_wr = (cfg_wdata[rpop_pkg::OFFSET_BITS-1:0] == rpop_pkg::OFFSET_RAW_MIN)
                       ? rpop_pkg::OFFSET_MIN : cfg_wdata[rpop_pkg::OFFSET_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_enables_reg        <= '0;
            contrast_gain_reg     <= rpop_pkg::UNITY_GAIN;
            brightness_offset_reg <= '0;
            channel_keep_reg      <= '0;
        end else if (cfg_wr_en) begin
            case (rpop_pkg::cfg_reg_t'(cfg_index))
                rpop_pkg::REG_OP_ENABLES: begin
                    op_enables_reg <= cfg_wdata[rpop_pkg::OPS_BITS-1:0];
                end
                rpop_pkg::REG_CONTRAST_GAIN: begin
                    contrast_gain_reg <= cfg_wdata[rpop_pkg::GAIN_BITS-1:0];
                end
                rpop_pkg::REG_BRIGHTNESS_OFFSET: begin
                    brightness_offset_reg <= offset_wr;
                end
                rpop_pkg::REG_CHANNEL_KEEP: begin
                    channel_keep_reg <= cfg_wdata[rpop_pkg::KEEP_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------- flow control ----------------

    assign rdy_out = !m_valid_reg || m_ready;
    assign rdy2    = !v2_reg || rdy_out;
    assign rdy1    = !v1_reg || rdy2;
    assign rdy0    = !v0_reg || rdy1;
    assign s_ready = rdy0;
    assign s_fire  = s_valid && rdy0;
    assign adv1    = v1_reg && rdy2;
    assign adv2    = v2_reg && rdy_out;

    // table writes leave the pipe here, in order with the pixel reads behind them
    assign ram_we = adv1 && (func1_reg == rpop_pkg::FUNC_LUT_WRITE);
    assign ram_re = adv1 && (func1_reg == rpop_pkg::FUNC_PIXEL);

    // ---------------- datapath ----------------

    assign chan_in[rpop_pkg::CH_BLUE]  = in0_reg.in_blue;
    assign chan_in[rpop_pkg::CH_GREEN] = in0_reg.in_green;
    assign chan_in[rpop_pkg::CH_RED]   = in0_reg.in_red;

    // a disabled contrast multiplies by one, which the rounding leaves exact
    assign gain_sel = op_enables_reg[rpop_pkg::EN_CONTRAST] ? contrast_gain_reg
                                                             : rpop_pkg::UNITY_GAIN;

    assign keep = (channel_keep_reg == '0) ? '1 : channel_keep_reg;

    always_comb begin
        for (int c = 0; c < rpop_pkg::NUM_CH; c++) begin
            // stage 0: invert and multiply
            inv_val[c]    = op_enables_reg[rpop_pkg::EN_INVERT]
                            ? rpop_pkg::CH_MAX - chan_in[c] : chan_in[c];
            prod1_next[c] = rpop_pkg::PROD_BITS'(inv_val[c])
                            * rpop_pkg::PROD_BITS'(gain_sel);

            // stage 1: round half up, saturate, then brightness
            rnd_val[c] = {1'b0, prod1_reg[c]} + rpop_pkg::RND_HALF;
            shf_val[c] = rnd_val[c][rpop_pkg::PROD_BITS:rpop_pkg::GAIN_FRAC_BITS];
            con_val[c] = (|shf_val[c][rpop_pkg::SHIFT_BITS-1:rpop_pkg::CHANNEL_BITS])
                         ? rpop_pkg::CH_MAX : shf_val[c][rpop_pkg::CHANNEL_BITS-1:0];
            sum_val[c] = {2'b00, con_val[c]}
                         + {brightness_offset_reg[rpop_pkg::OFFSET_BITS-1],
                            brightness_offset_reg};
            if (!op_enables_reg[rpop_pkg::EN_BRIGHT]) begin
                brt_val[c] = con_val[c];
            end else if (sum_val[c][rpop_pkg::SUM_BITS-1]) begin
                brt_val[c] = '0;
            end else if (sum_val[c][rpop_pkg::CHANNEL_BITS]) begin
                brt_val[c] = rpop_pkg::CH_MAX;
            end else begin
                brt_val[c] = sum_val[c][rpop_pkg::CHANNEL_BITS-1:0];
            end
            val2_next[c] = ram_re ? brt_val[c] : val2_reg[c];

            // stage 2: gamma select and channel masking
            gam_val[c] = op_enables_reg[rpop_pkg::EN_GAMMA] ? ram_rd[c] : val2_reg[c];
            fin_val[c] = keep[c] ? gam_val[c] : '0;
        end
    end

    genvar g;
    generate
        for (g = 0; g < rpop_pkg::NUM_CH; g++) begin : g_lut
            rpop_ram #(
                .WIDTH (rpop_pkg::CHANNEL_BITS),
                .DEPTH (rpop_pkg::LUT_DEPTH)
            ) u_lut (
                .aclk    (aclk),
                .wr_en   (ram_we),
                .wr_addr (lidx1_reg),
                .wr_data (lval1_reg),
                .rd_en   (ram_re),
                .rd_addr (brt_val[g]),
                .rd_data (ram_rd[g])
            );
        end
    endgenerate

    // ---------------- pipeline registers ----------------

    always_comb begin
        v0_next      = rdy0 ? s_valid : v0_reg;
        in0_next     = s_fire ? s_data : in0_reg;
        v1_next      = rdy1 ? v0_reg : v1_reg;
        v2_next      = rdy2 ? ram_re : v2_reg;
        m_valid_next = rdy_out ? v2_reg : m_valid_reg;
        m_data_next  = m_data_reg;
        if (adv2) begin
            m_data_next.out_blue  = fin_val[rpop_pkg::CH_BLUE];
            m_data_next.out_green = fin_val[rpop_pkg::CH_GREEN];
            m_data_next.out_red   = fin_val[rpop_pkg::CH_RED];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg      <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            v0_reg      <= v0_next;
            v1_reg      <= v1_next;
            v2_reg      <= v2_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in0_reg    <= in0_next;
        m_data_reg <= m_data_next;
        for (int c = 0; c < rpop_pkg::NUM_CH; c++) begin
            val2_reg[c] <= val2_next[c];
        end
        if (v0_reg && rdy1) begin
            func1_reg <= in0_reg.func;
            lidx1_reg <= in0_reg.lut_index;
            lval1_reg <= in0_reg.lut_value;
            for (int c = 0; c < rpop_pkg::NUM_CH; c++) begin
                prod1_reg[c] <= prod1_next[c];
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ---------------- assertions ----------------

    // a table write never turns into a result
    `RPOP_ASSERT_NEXT(a_lut_write_no_result, ram_we, !v2_reg, "table write reached stage two")
    // ram is never written and read in the same cycle
    `RPOP_ASSERT_NOW(a_ram_one_port, ram_we, !ram_re, "gamma ram written and read together")
    // a stalled lookup keeps its place while the output waits
    `RPOP_ASSERT_NEXT(a_stage2_held, v2_reg && !rdy_out, v2_reg, "stage two dropped a pixel")
    // a new result only ever comes from a valid lookup stage
    `RPOP_ASSERT_NOW(a_out_from_stage2, $rose(m_valid_reg), $past(v2_reg),
                     "result appeared without a pixel in stage two")

endmodule
